>>> sv/ved_pkg.sv
package ved_pkg;

  localparam int COUNT_BITS_DEF = 20;
  localparam int SUM_W          = 36;
  localparam int SOS_W          = 32;
  localparam int MAG_W          = 16;
  localparam int ROOT_REM_W     = 17;
  localparam int ROOT_STEPS     = 16;
  localparam int DIV_STEPS      = SUM_W;
  localparam int CFG_IDX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DURATION    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TIME   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT_INT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_ON   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_OFF  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_EN    = 8'd5;

  localparam logic [31:0] DURATION_RST   = 32'd0;
  localparam logic [31:0] BASE_TIME_RST  = 32'd1000000;
  localparam logic [31:0] REPORT_INT_RST = 32'd50000;
  localparam logic [15:0] THRESH_ON_RST  = 16'd8197;
  localparam logic [15:0] THRESH_OFF_RST = 16'd3279;

  typedef struct packed {
    logic [31:0]        now_us;
    logic signed [15:0] x_raw;
    logic signed [15:0] y_raw;
    logic signed [15:0] z_raw;
  } ved_in_t;

  typedef struct packed {
    logic        ended;
    logic [31:0] relative_time_us;
    logic [15:0] magnitude;
    logic [15:0] deviation;
    logic        baseline_ready;
    logic [15:0] baseline_value;
    logic        event_active;
    logic        report_due;
    logic [31:0] samples_taken;
  } ved_out_t;

  // operation of the shared multiply / shift-subtract unit
  typedef enum logic [2:0] {
    AOP_NONE      = 3'd0,
    AOP_SQ_X      = 3'd1,
    AOP_SQ_Y      = 3'd2,
    AOP_SQ_Z      = 3'd3,
    AOP_ROOT_INIT = 3'd4,
    AOP_ROOT_STEP = 3'd5,
    AOP_DIV_INIT  = 3'd6,
    AOP_DIV_STEP  = 3'd7
  } aop_t;

  typedef struct packed {
    logic in_ready;
    aop_t op;
    logic check;
    logic acc;
    logic base;
    logic update;
    logic emit;
  } ved_ctrl_t;

  typedef struct packed {
    logic start;
    logic drop;
    logic need_div;
    logic out_free;
  } ved_stat_t;

endpackage

>>> sv/ved_arith.sv
module ved_arith #(
  parameter int COUNT_BITS = ved_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  ved_pkg::aop_t                op,
  input  logic signed [15:0]           x_raw,
  input  logic signed [15:0]           y_raw,
  input  logic signed [15:0]           z_raw,
  input  logic [ved_pkg::SUM_W-1:0]    sum,
  input  logic [COUNT_BITS-1:0]        count,
  output logic [ved_pkg::MAG_W-1:0]    mag,
  output logic [ved_pkg::SUM_W-1:0]    quot
);

  localparam int REM_W = (COUNT_BITS > ved_pkg::ROOT_REM_W) ? COUNT_BITS : ved_pkg::ROOT_REM_W;
  localparam int SUB_W = REM_W + 2;

  logic [ved_pkg::SOS_W-1:0] prod;
  logic [ved_pkg::SOS_W-1:0] acc;
  logic [ved_pkg::SOS_W-1:0] sos;
  logic [ved_pkg::SUM_W-1:0] shreg;
  logic [REM_W-1:0]          rem;
  logic [ved_pkg::MAG_W-1:0] root;

  logic signed [15:0] axis;
  logic signed [31:0] sq;
  logic [SUB_W-1:0]   sub_a;
  logic [SUB_W-1:0]   sub_b;
  logic [SUB_W:0]     diff;
  logic               ge;

  always_comb begin
    case (op)
      ved_pkg::AOP_SQ_X: axis = x_raw;
      ved_pkg::AOP_SQ_Y: axis = y_raw;
      default:           axis = z_raw;
    endcase
  end

  assign sq  = axis * axis;
  assign sos = acc + prod;

  // one subtractor serves both the root digit test and the divide step
  always_comb begin
    if (op == ved_pkg::AOP_ROOT_STEP) begin
      sub_a = SUB_W'({rem[ved_pkg::ROOT_REM_W-1:0], shreg[ved_pkg::SUM_W-1 -: 2]});
      sub_b = SUB_W'({root, 2'b01});
    end else begin
      sub_a = SUB_W'({rem[COUNT_BITS-1:0], shreg[ved_pkg::SUM_W-1]});
      sub_b = SUB_W'(count);
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[SUB_W];

  always_ff @(posedge clk) begin
    case (op)
      ved_pkg::AOP_SQ_X: begin
        prod <= unsigned'(sq);
      end
      ved_pkg::AOP_SQ_Y: begin
        prod <= unsigned'(sq);
        acc  <= prod;
      end
      ved_pkg::AOP_SQ_Z: begin
        prod <= unsigned'(sq);
        acc  <= sos;
      end
      ved_pkg::AOP_ROOT_INIT: begin
        shreg <= {sos, {(ved_pkg::SUM_W - ved_pkg::SOS_W){1'b0}}};
        rem   <= '0;
        root  <= '0;
      end
      ved_pkg::AOP_ROOT_STEP: begin
        rem   <= ge ? REM_W'(diff[SUB_W-1:0]) : REM_W'(sub_a);
        root  <= {root[ved_pkg::MAG_W-2:0], ge};
        shreg <= {shreg[ved_pkg::SUM_W-3:0], 2'b00};
      end
      ved_pkg::AOP_DIV_INIT: begin
        shreg <= sum;
        rem   <= '0;
      end
      ved_pkg::AOP_DIV_STEP: begin
        rem   <= ge ? REM_W'(diff[SUB_W-1:0]) : REM_W'(sub_a);
        shreg <= {shreg[ved_pkg::SUM_W-2:0], ge};
      end
      default: begin
      end
    endcase
  end

  assign mag  = root;
  assign quot = shreg;

endmodule

>>> sv/ved_seq.sv
module ved_seq (
  input  logic               clk,
  input  logic               rst,
  input  ved_pkg::ved_stat_t stat,
  output ved_pkg::ved_ctrl_t ctrl
);

  localparam int CNT_W = $clog2(ved_pkg::DIV_STEPS);

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_CHECK     = 13'b0000000000010,
    S_SQ_X      = 13'b0000000000100,
    S_SQ_Y      = 13'b0000000001000,
    S_SQ_Z      = 13'b0000000010000,
    S_ROOT_INIT = 13'b0000000100000,
    S_ROOT      = 13'b0000001000000,
    S_ACC       = 13'b0000010000000,
    S_DIV_INIT  = 13'b0000100000000,
    S_DIV       = 13'b0001000000000,
    S_BASE      = 13'b0010000000000,
    S_UPDATE    = 13'b0100000000000,
    S_EMIT      = 13'b1000000000000
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] step;
  logic [CNT_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    ctrl       = '0;
    ctrl.op    = ved_pkg::AOP_NONE;
    unique case (state)
      S_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (stat.start) state_next = S_CHECK;
      end
      S_CHECK: begin
        ctrl.check = 1'b1;
        state_next = stat.drop ? S_EMIT : S_SQ_X;
      end
      S_SQ_X: begin
        ctrl.op    = ved_pkg::AOP_SQ_X;
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        ctrl.op    = ved_pkg::AOP_SQ_Y;
        state_next = S_SQ_Z;
      end
      S_SQ_Z: begin
        ctrl.op    = ved_pkg::AOP_SQ_Z;
        state_next = S_ROOT_INIT;
      end
      S_ROOT_INIT: begin
        ctrl.op    = ved_pkg::AOP_ROOT_INIT;
        step_next  = '0;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        ctrl.op   = ved_pkg::AOP_ROOT_STEP;
        step_next = step + 1'b1;
        if (step == CNT_W'(ved_pkg::ROOT_STEPS - 1)) state_next = S_ACC;
      end
      S_ACC: begin
        ctrl.acc   = 1'b1;
        state_next = stat.need_div ? S_DIV_INIT : S_UPDATE;
      end
      S_DIV_INIT: begin
        ctrl.op    = ved_pkg::AOP_DIV_INIT;
        step_next  = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctrl.op   = ved_pkg::AOP_DIV_STEP;
        step_next = step + 1'b1;
        if (step == CNT_W'(ved_pkg::DIV_STEPS - 1)) state_next = S_BASE;
      end
      S_BASE: begin
        ctrl.base  = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        ctrl.update = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        ctrl.emit = 1'b1;
        if (stat.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

>>> sv/vibration_event_detector_unit.sv
// Vibration event detector: one three-axis accelerometer request in, one
// result request out.
// in channel  (in_valid/in_ready/in_data): sample time and raw x/y/z axes.
// out channel (out_valid/out_ready/out_data): magnitude, deviation from the
//   baseline, event and report flags, sample count, end-of-collection flag.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   ready out of reset; write only while the block is idle. Unknown indexes ignored.
// Timing: one request at a time. A normal sample steps through check, the
//   three squares, root init, the root steps, accumulate, update and emit;
//   the sample that closes the baseline window adds a 36-step restoring divide
//   for the average. A dropped sample (collection ended) goes from check to emit.
//   The 16-step square root and the divide share one subtractor, so those step
//   counts set the rate; in_ready comes back the cycle after the result is loaded.
// Stall: the result sits in a one-entry output register; the next request is
//   taken while it waits, and that request's result holds at its last step
//   until the output register frees.
// Reset (rst, synchronous): registers return to their defaults, all detector
//   state clears, the output register empties; no channel is ready in reset.
module vibration_event_detector_unit #(
  parameter int COUNT_BITS = ved_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  ved_pkg::ved_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output ved_pkg::ved_out_t                out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ved_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);

  // configuration registers
  logic [31:0] duration_us;
  logic [31:0] baseline_time_us;
  logic [31:0] report_interval_us;
  logic [15:0] threshold_on;
  logic [15:0] threshold_off;
  logic        event_enable;

  // detector state
  logic                      started;
  logic [31:0]               start_time;
  logic [31:0]               last_report_time;
  logic                      finished;
  logic                      baseline_done;
  logic [ved_pkg::SUM_W-1:0] baseline_sum;
  logic [COUNT_BITS-1:0]     baseline_count;
  logic [15:0]               baseline_mag;
  logic                      event_flag;
  logic [31:0]               sample_count;

  // per-request working registers
  ved_pkg::ved_in_t  sample;
  logic [31:0]       rel_t;
  ved_pkg::ved_out_t res;

  ved_pkg::ved_ctrl_t ctrl;
  ved_pkg::ved_stat_t stat;

  logic [15:0]               mag;
  logic [ved_pkg::SUM_W-1:0] quot;

  logic [31:0]             t_calc;
  logic                    drop;
  logic [ved_pkg::SUM_W:0] sum_ext;
  logic [15:0]             dev;
  logic                    ev_on;
  logic                    ev_next;
  logic [31:0]             count_next;
  logic [31:0]             since_report;
  logic                    due;
  logic                    out_free;

  assign cfg_ready = ~rst;
  assign in_ready  = ctrl.in_ready & ~rst;
  assign out_free  = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration_us        <= ved_pkg::DURATION_RST;
      baseline_time_us   <= ved_pkg::BASE_TIME_RST;
      report_interval_us <= ved_pkg::REPORT_INT_RST;
      threshold_on       <= ved_pkg::THRESH_ON_RST;
      threshold_off      <= ved_pkg::THRESH_OFF_RST;
      event_enable       <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ved_pkg::REG_DURATION:   duration_us        <= cfg_data;
        ved_pkg::REG_BASE_TIME:  baseline_time_us   <= cfg_data;
        ved_pkg::REG_REPORT_INT: report_interval_us <= cfg_data;
        ved_pkg::REG_THRESH_ON:  threshold_on       <= cfg_data[15:0];
        ved_pkg::REG_THRESH_OFF: threshold_off      <= cfg_data[15:0];
        ved_pkg::REG_EVENT_EN:   event_enable       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // first sample of a run sets the time origin
  assign t_calc = started ? (sample.now_us - start_time) : 32'd0;
  assign drop   = finished | ((duration_us != 32'd0) && (t_calc >= duration_us));

  assign stat.start    = in_valid;
  assign stat.drop     = drop;
  assign stat.need_div = ~baseline_done && (rel_t >= baseline_time_us);
  assign stat.out_free = out_free;

  // baseline sum saturates at all ones
  assign sum_ext = {1'b0, baseline_sum} + (ved_pkg::SUM_W + 1)'(mag);

  // deviation is zero until the baseline exists
  always_comb begin
    if (!baseline_done) dev = 16'd0;
    else if (mag >= baseline_mag) dev = mag - baseline_mag;
    else dev = baseline_mag - mag;
  end

  // turn-on test first, turn-off test on the result of it
  assign ev_on   = event_flag | (dev > threshold_on);
  assign ev_next = (baseline_done && event_enable) ? (ev_on & ~(dev < threshold_off))
                                                   : event_flag;

  assign count_next   = (sample_count == 32'hFFFF_FFFF) ? sample_count : sample_count + 32'd1;
  assign since_report = sample.now_us - last_report_time;
  assign due          = since_report >= report_interval_us;

  always_ff @(posedge clk) begin
    if (ctrl.in_ready && in_valid) sample <= in_data;

    if (ctrl.check) begin
      rel_t <= t_calc;
      // dropped result carries held state only
      res.ended            <= 1'b1;
      res.relative_time_us <= '0;
      res.magnitude        <= '0;
      res.deviation        <= '0;
      res.baseline_ready   <= baseline_done;
      res.baseline_value   <= baseline_mag;
      res.event_active     <= event_flag;
      res.report_due       <= 1'b0;
      res.samples_taken    <= sample_count;
    end

    if (ctrl.update) begin
      res.ended            <= 1'b0;
      res.relative_time_us <= rel_t;
      res.magnitude        <= mag;
      res.deviation        <= dev;
      res.baseline_ready   <= baseline_done;
      res.baseline_value   <= baseline_mag;
      res.event_active     <= ev_next;
      res.report_due       <= due;
      res.samples_taken    <= count_next;
    end

    if (ctrl.emit && out_free) out_data <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started          <= 1'b0;
      start_time       <= '0;
      last_report_time <= '0;
      finished         <= 1'b0;
      baseline_done    <= 1'b0;
      baseline_sum     <= '0;
      baseline_count   <= '0;
      baseline_mag     <= '0;
      event_flag       <= 1'b0;
      sample_count     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (ctrl.check && !finished) begin
        if (!started) begin
          start_time       <= sample.now_us;
          last_report_time <= sample.now_us;
          started          <= 1'b1;
        end
        if (drop) finished <= 1'b1;
      end

      if (ctrl.acc && !baseline_done) begin
        baseline_sum <= sum_ext[ved_pkg::SUM_W] ? {ved_pkg::SUM_W{1'b1}}
                                                : sum_ext[ved_pkg::SUM_W-1:0];
        if (baseline_count != {COUNT_BITS{1'b1}}) baseline_count <= baseline_count + 1'b1;
      end

      if (ctrl.base) begin
        // quotient only exceeds 16 bits after count saturation
        baseline_mag  <= (quot[ved_pkg::SUM_W-1:16] != '0) ? 16'hFFFF : quot[15:0];
        baseline_done <= 1'b1;
      end

      if (ctrl.update) begin
        event_flag   <= ev_next;
        sample_count <= count_next;
        if (due) last_report_time <= sample.now_us;
      end

      if (ctrl.emit && out_free) out_valid <= 1'b1;
      else if (out_ready)        out_valid <= 1'b0;
    end
  end

  ved_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  ved_arith #(
    .COUNT_BITS (COUNT_BITS)
  ) u_arith (
    .clk   (clk),
    .op    (ctrl.op),
    .x_raw (sample.x_raw),
    .y_raw (sample.y_raw),
    .z_raw (sample.z_raw),
    .sum   (baseline_sum),
    .count (baseline_count),
    .mag   (mag),
    .quot  (quot)
  );

endmodule
